### rtl/sha256_message_hasher_core_assert.svh
// ---------------------------------------------------------------------------
// SHA-256 message hasher assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA_CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sha256_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants, initial hash values and sigma functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hash_t;

	// Control from the sequencer to a datapath unit.
	typedef struct packed {
		logic load;
		logic step;
	} seq_ctl_t;

	localparam int unsigned ROUNDS = 64;
	localparam int unsigned BLOCK_WORDS = 16;

	localparam word_t PAD_MARKER = 32'h8000_0000;

	localparam word_t IV_TABLE [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t K_TABLE [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

`default_nettype wire

### rtl/sha256_message_hasher_core.sv
// ---------------------------------------------------------------------------
// SHA-256 message hasher core
// Hashes a stream of big-endian message words and returns the eight digest words.
// ---------------------------------------------------------------------------
//  Channel   Handshake                     Payload
//  message   msg_valid / msg_stall         message_word, byte_count, last
//  digest    digest_valid / digest_stall   digest_word, digest_index, digest_last
//
// A word that does not complete a block leaves the core idle for the next word;
// a word that completes one starts the compression rounds of the single round
// unit, followed by the chaining update. The last word also inserts one padding
// word per cycle outside compressions, one or two compressions and eight digest transfers.
// Reset loads the initial hash values and clears the length and position.
// A stalled digest holds its word until the transfer completes.
`timescale 1ns / 1ps
`default_nettype none

module sha256_message_hasher_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        msg_valid,
	output logic             msg_stall,
	input  wire logic [31:0] message_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last,
	output logic             digest_valid,
	input  wire logic        digest_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       digest_index,
	output logic             digest_last
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PAD  = 5'b00010,
		ST_COMP = 5'b00100,
		ST_ADD  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		PH_MARK  = 3'b001,
		PH_ZERO  = 3'b010,
		PH_LENLO = 3'b100
	} phase_t;

	state_t                state_q, state_d, ret_q, ret_d;
	phase_t                phase_q, phase_d;
	logic [3:0]            pos_q;
	logic [5:0]            rnd_q;
	logic [2:0]            idx_q;
	logic [63:0]           bitlen_q;
	sha256_pkg::hash_t     chain_q;
	sha256_pkg::hash_t     work_vars;
	sha256_pkg::word_t     sched_word;
	sha256_pkg::word_t     put_data;
	logic                  put_en;
	logic                  digest_xfer;
	logic                  msg_xfer;
	sha256_pkg::seq_ctl_t  sched_ctl;
	sha256_pkg::seq_ctl_t  round_ctl;

	assign msg_stall    = (state_q != ST_IDLE);
	assign msg_xfer     = msg_valid && !msg_stall;
	assign digest_valid = (state_q == ST_OUT);
	assign digest_xfer  = digest_valid && !digest_stall;
	assign digest_word  = chain_q[0];
	assign digest_index = idx_q;
	assign digest_last  = (idx_q == 3'd7);

	always_comb begin
		put_en   = 1'b0;
		put_data = '0;
		state_d  = state_q;
		phase_d  = phase_q;
		ret_d    = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_valid) begin
					put_en = 1'b1;
					if (!last) begin
						put_data = message_word;
					end else begin
						phase_d = PH_ZERO;
						unique case (byte_count)
							3'd0: put_data = sha256_pkg::PAD_MARKER;
							3'd1: put_data = {message_word[31:24], 24'h80_0000};
							3'd2: put_data = {message_word[31:16], 16'h8000};
							3'd3: put_data = {message_word[31:8], 8'h80};
							default: begin
								put_data = message_word;
								phase_d  = PH_MARK;
							end
						endcase
					end
					if (pos_q == 4'hF) begin
						state_d = ST_COMP;
						ret_d   = last ? ST_PAD : ST_IDLE;
					end else begin
						state_d = last ? ST_PAD : ST_IDLE;
					end
				end
			end
			ST_PAD: begin
				put_en = 1'b1;
				unique case (phase_q)
					PH_MARK: begin
						put_data = sha256_pkg::PAD_MARKER;
						phase_d  = PH_ZERO;
					end
					PH_ZERO: begin
						if (pos_q == 4'hE) begin
							put_data = bitlen_q[63:32];
							phase_d  = PH_LENLO;
						end
					end
					PH_LENLO: put_data = bitlen_q[31:0];
					default: put_data = '0;
				endcase
				if (pos_q == 4'hF) begin
					state_d = ST_COMP;
					ret_d   = (phase_q == PH_LENLO) ? ST_OUT : ST_PAD;
				end
			end
			ST_COMP: begin
				if (rnd_q == 6'd63) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: state_d = ret_q;
			ST_OUT: begin
				if (digest_xfer && idx_q == 3'd7) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign sched_ctl = '{load: put_en, step: (state_q == ST_COMP)};
	assign round_ctl = '{load: put_en && (pos_q == 4'hF), step: (state_q == ST_COMP)};

	sha256_sched u_sched (
		.clk        (clk),
		.ctl        (sched_ctl),
		.load_word  (put_data),
		.sched_word (sched_word)
	);

	sha256_round u_round (
		.clk         (clk),
		.ctl         (round_ctl),
		.init_vars   (chain_q),
		.round_const (sha256_pkg::K_TABLE[rnd_q]),
		.sched_word  (sched_word),
		.work_vars   (work_vars)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			phase_q  <= PH_ZERO;
			pos_q    <= '0;
			rnd_q    <= '0;
			idx_q    <= '0;
			bitlen_q <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha256_pkg::IV_TABLE[i];
			end
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			phase_q <= phase_d;
			if (put_en) begin
				pos_q <= pos_q + 4'd1;
			end
			if (state_q == ST_COMP) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (msg_xfer) begin
				if (!last) begin
					bitlen_q <= bitlen_q + 64'd32;
				end else if (byte_count > 3'd4) begin
					bitlen_q <= bitlen_q + 64'd32;
				end else begin
					bitlen_q <= bitlen_q + {58'd0, byte_count, 3'b000};
				end
			end
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + work_vars[i];
				end
			end
			if (digest_xfer) begin
				for (int i = 0; i < 7; i++) begin
					chain_q[i] <= chain_q[i + 1];
				end
				chain_q[7] <= sha256_pkg::IV_TABLE[idx_q];
				idx_q      <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					bitlen_q <= '0;
				end
			end
		end
	end

`include "sha256_message_hasher_core_assert.svh"

	`SHA_CHK_SAME(a_comp_full, state_q == ST_COMP, pos_q == 4'h0, "compression with partial block")
	`SHA_CHK_SAME(a_lenlo_slot, (state_q == ST_PAD) && (phase_q == PH_LENLO), pos_q == 4'hF, "length low word not in final slot")
	`SHA_CHK_NEXT(a_add_after, (state_q == ST_COMP) && (rnd_q == 6'd63), state_q == ST_ADD, "no chaining update after last round")
	`SHA_CHK_NEXT(a_iv_restore, digest_xfer && digest_last, (chain_q[0] == sha256_pkg::IV_TABLE[0]) && (chain_q[7] == sha256_pkg::IV_TABLE[7]) && (bitlen_q == 64'd0), "state not restored after digest")

endmodule

`default_nettype wire

### rtl/sha256_sched.sv
// ---------------------------------------------------------------------------
// SHA-256 message schedule window
// Sixteen-word shift window that collects block words and expands the schedule.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_sched (
	input  wire logic                clk,
	input  wire sha256_pkg::seq_ctl_t ctl,
	input  wire sha256_pkg::word_t    load_word,
	output sha256_pkg::word_t         sched_word
);

	sha256_pkg::word_t win_q [sha256_pkg::BLOCK_WORDS];
	sha256_pkg::word_t next_word;

	assign next_word = win_q[0] + sha256_pkg::small_sigma0(win_q[1]) + win_q[9]
		+ sha256_pkg::small_sigma1(win_q[14]);

	assign sched_word = win_q[0];

	always_ff @(posedge clk) begin
		if (ctl.load || ctl.step) begin
			for (int i = 0; i < sha256_pkg::BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[sha256_pkg::BLOCK_WORDS - 1] <= ctl.load ? load_word : next_word;
		end
	end

endmodule

`default_nettype wire

### rtl/sha256_round.sv
// ---------------------------------------------------------------------------
// SHA-256 round unit
// Working registers a to h and the compression round applied once per cycle while step is set.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_round (
	input  wire logic                 clk,
	input  wire sha256_pkg::seq_ctl_t ctl,
	input  wire sha256_pkg::hash_t    init_vars,
	input  wire sha256_pkg::word_t    round_const,
	input  wire sha256_pkg::word_t    sched_word,
	output sha256_pkg::hash_t         work_vars
);

	sha256_pkg::hash_t wv_q;
	sha256_pkg::word_t t1;
	sha256_pkg::word_t t2;
	sha256_pkg::word_t choose;
	sha256_pkg::word_t major;

	assign choose = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign major  = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t1 = wv_q[7] + sha256_pkg::big_sigma1(wv_q[4]) + choose + round_const + sched_word;
	assign t2 = sha256_pkg::big_sigma0(wv_q[0]) + major;

	assign work_vars = wv_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			wv_q <= init_vars;
		end else if (ctl.step) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

endmodule

`default_nettype wire

### tb/sha256_message_hasher_checker.sv
// ---------------------------------------------------------------------------
// SHA-256 message hasher checker
// Watches both channels of the hasher, keeps its own SHA-256 state, and
// compares every digest transfer field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_message_hasher_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	input  logic        msg_stall,
	input  logic [31:0] message_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	input  logic        digest_valid,
	input  logic        digest_stall,
	input  logic [31:0] digest_word,
	input  logic [2:0]  digest_index,
	input  logic        digest_last,
	output int          pending,
	output int          fail_count
);

	localparam logic [31:0] PAD_WORD = 32'h8000_0000;
	localparam logic [31:0] PAD_BYTE = 32'h0000_0080;
	localparam int DIGEST_WORDS = 8;
	localparam int FULL_BYTES = 4;

	localparam logic [31:0] START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        final_word;
	} digest_item_t;

	logic [31:0] chain [8];
	logic [31:0] block_buf [16];
	logic [63:0] bit_count;
	logic [3:0]  fill_pos;
	digest_item_t digest_queue [$];
	digest_item_t want;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void compress_block();
		logic [31:0] sched [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			sched[i] = block_buf[i];
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
			s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
			sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + sched[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endfunction

	function automatic void push_block_word(input logic [31:0] w);
		block_buf[fill_pos] = w;
		fill_pos = fill_pos + 4'd1;
		if (fill_pos == 4'd0)
			compress_block();
	endfunction

	function automatic void start_message();
		for (int i = 0; i < 8; i++)
			chain[i] = START_HASH[i];
		bit_count = '0;
		fill_pos = '0;
	endfunction

	// Absorbs one word; the last word pads the message and queues its digest.
	function automatic void absorb_word(input logic [31:0] w, input logic [2:0] cnt_in,
			input logic is_last);
		int cnt;
		logic [31:0] keep;
		digest_item_t item;
		if (!is_last) begin
			bit_count = bit_count + 64'd32;
			push_block_word(w);
			return;
		end
		cnt = (cnt_in > FULL_BYTES) ? FULL_BYTES : cnt_in;
		bit_count = bit_count + 64'(8 * cnt);
		if (cnt == FULL_BYTES) begin
			push_block_word(w);
			push_block_word(PAD_WORD);
		end else begin
			keep = (cnt == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * cnt));
			push_block_word((w & keep) | (PAD_BYTE << (24 - 8 * cnt)));
		end
		if (fill_pos > 4'd14) begin
			while (fill_pos != 4'd0)
				push_block_word(32'h0);
		end
		while (fill_pos < 4'd14)
			push_block_word(32'h0);
		push_block_word(bit_count[63:32]);
		push_block_word(bit_count[31:0]);
		for (int i = 0; i < DIGEST_WORDS; i++) begin
			item.word = chain[i];
			item.index = 3'(i);
			item.final_word = (i == DIGEST_WORDS - 1);
			digest_queue.push_back(item);
		end
		start_message();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_message();
			digest_queue.delete();
			fail_count = 0;
		end else begin
			if (digest_valid && !digest_stall) begin
				if (digest_queue.size() == 0) begin
					$error("digest transfer with no digest predicted: word %h index %0d",
						digest_word, digest_index);
					fail_count++;
				end else begin
					want = digest_queue.pop_front();
					if (digest_word !== want.word) begin
						$error("digest_word: expected %h, actual %h", want.word, digest_word);
						fail_count++;
					end
					if (digest_index !== want.index) begin
						$error("digest_index: expected %0d, actual %0d", want.index,
							digest_index);
						fail_count++;
					end
					if (digest_last !== want.final_word) begin
						$error("digest_last: expected %b, actual %b", want.final_word,
							digest_last);
						fail_count++;
					end
				end
			end
			if (msg_valid && !msg_stall)
				absorb_word(message_word, byte_count, last);
		end
		pending = digest_queue.size();
	end

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams directed and random messages into the hasher with random gaps and
// digest stalls, while the checker predicts and compares every digest word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int WORD_TARGET = 320;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_CYCLES = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        msg_valid = 1'b0;
	logic        msg_stall;
	logic [31:0] message_word = '0;
	logic [2:0]  byte_count = '0;
	logic        last = 1'b0;
	logic        digest_valid;
	logic        digest_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  digest_index;
	logic        digest_last;
	int          pending;
	int          fail_count;

	int words_sent = 0;
	int idle_cycles = 0;
	int stall_run = 0;
	int calm_run = 0;
	int sender_calm = 0;
	int roll;

	always #6 clk = ~clk;

	sha256_message_hasher_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.message_word (message_word),
		.byte_count   (byte_count),
		.last         (last),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_word  (digest_word),
		.digest_index (digest_index),
		.digest_last  (digest_last)
	);

	sha256_message_hasher_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.message_word (message_word),
		.byte_count   (byte_count),
		.last         (last),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_word  (digest_word),
		.digest_index (digest_index),
		.digest_last  (digest_last),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	// Digest stalls come in short and long bursts, with calm stretches between.
	always @(negedge clk) begin
		if (calm_run > 0) begin
			calm_run--;
			digest_stall <= 1'b0;
		end else if (stall_run > 0) begin
			stall_run--;
			digest_stall <= 1'b1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				calm_run = $urandom_range(20, 120);
			else if (roll < 8)
				stall_run = $urandom_range(8, 40);
			else if (roll < 35)
				stall_run = $urandom_range(1, 3);
			digest_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((msg_valid && !msg_stall) || (digest_valid && !digest_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic is_last);
		@(negedge clk);
		msg_valid <= 1'b1;
		message_word <= w;
		byte_count <= cnt;
		last <= is_last;
		do @(posedge clk); while (msg_stall);
		words_sent++;
	endtask

	task automatic sender_gap();
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (sender_calm > 0) begin
			sender_calm--;
			gap = 0;
		end else if (r < 3) begin
			sender_calm = $urandom_range(10, 40);
			gap = 0;
		end else if (r < 55) begin
			gap = 0;
		end else if (r < 90) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(8, 40);
		end
		if (gap > 0) begin
			@(negedge clk);
			msg_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_digests();
		@(negedge clk);
		msg_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Full words before the last word, then the last word with its byte count.
	task automatic send_message(input int body_words, input bit noisy_count,
			input logic [2:0] final_count, input logic [31:0] final_word);
		for (int i = 0; i < body_words; i++) begin
			send_word($urandom, noisy_count ? 3'($urandom_range(0, 7)) : 3'd4, 1'b0);
			sender_gap();
		end
		send_word(final_word, final_count, 1'b1);
		sender_gap();
	endtask

	task automatic random_message();
		int r;
		int body;
		r = $urandom_range(0, 99);
		if (r < 45)
			body = $urandom_range(0, 6);
		else if (r < 75)
			body = $urandom_range(12, 17);
		else if (r < 92)
			body = $urandom_range(7, 31);
		else
			body = $urandom_range(32, 48);
		send_message(body, $urandom_range(0, 9) < 3, 3'($urandom_range(0, 7)), $urandom);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Empty message, partial last words with junk in the unused bytes,
		// a full last word, and byte counts above four.
		send_message(0, 1'b0, 3'd0, 32'hffff_ffff);
		send_message(0, 1'b0, 3'd1, 32'h0000_0000);
		send_message(0, 1'b0, 3'd2, $urandom);
		send_message(0, 1'b0, 3'd3, 32'h6162_63ff);
		send_message(0, 1'b0, 3'd4, 32'hffff_ffff);
		send_message(0, 1'b0, 3'd5, $urandom);
		send_message(0, 1'b0, 3'd6, $urandom);
		send_message(0, 1'b0, 3'd7, $urandom);
		// Byte count on a word that is not last must be ignored.
		send_message(1, 1'b1, 3'd4, $urandom);
		// The length no longer fits, so padding spills into a second block.
		send_message(14, 1'b0, 3'd1, $urandom);
		drain_digests();

		while (words_sent < WORD_TARGET) begin
			random_message();
			if ($urandom_range(0, 7) == 0)
				drain_digests();
		end

		@(negedge clk);
		msg_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
